[hw/rtl/tmpg_pkg.sv]
// tile map pixel generator: shared types, codes, constants and helpers
// no dependencies; imported by every module of the block
package tmpg_pkg;

  localparam int unsigned MemAw     = 13;
  localparam int unsigned DataW     = 8;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned RowW      = 9;
  localparam int unsigned CfgW      = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned TileColW  = 7;
  localparam int unsigned TileRowW  = 6;
  localparam int unsigned PixW      = 3;
  localparam int unsigned NibW      = 4;

  // coordinate offsets
  localparam logic [CoordW-1:0] ColOfs  = CoordW'(3);
  localparam logic [CoordW-1:0] RowOfs  = CoordW'(4);
  localparam logic [CoordW-1:0] ZoomOfs = CoordW'(2);

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    MEM_NAME    = 2'd0,
    MEM_ATTR    = 2'd1,
    MEM_PATTERN = 2'd2,
    MEM_PALETTE = 2'd3
  } mem_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEXT_EN   = 3'd0,
    CFG_ZOOM_H    = 3'd1,
    CFG_ZOOM_V    = 3'd2,
    CFG_SCROLL_H  = 3'd3,
    CFG_SCROLL_V  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              text_en;
    logic              zoom_h;
    logic              zoom_v;
    logic [CoordW-1:0] scroll_h;
    logic [CoordW-1:0] scroll_v;
  } cfg_t;

  // memory write carried along the pipe
  typedef struct packed {
    mem_sel_e         sel;
    logic [MemAw-1:0] addr;
    logic [DataW-1:0] data;
  } wr_t;

  // after coordinate mapping
  typedef struct packed {
    kind_e            kind;
    wr_t              wr;
    logic [MemAw-1:0] tile;
    logic [PixW-1:0]  px;
    logic [PixW-1:0]  py;
    logic             bank;
  } s1_t;

  // after name and attribute lookup
  typedef struct packed {
    kind_e            kind;
    wr_t              wr;
    logic [DataW-1:0] name;
    logic [DataW-1:0] attr;
    logic [PixW-1:0]  px;
    logic [PixW-1:0]  py;
    logic             bank;
  } s2_t;

  // after pattern fetch
  typedef struct packed {
    kind_e            kind;
    wr_t              wr;
    logic [DataW-1:0] pattern;
    logic [DataW-1:0] attr;
    logic             hi_nib;
    logic             bank;
  } s3_t;

  // 4-bit channel {hi, i_hi, lo, i_lo} repeated into 8 bits
  function automatic logic [DataW-1:0] expand_channel(logic hi, logic lo, logic [1:0] inten);
    logic [NibW-1:0] c4;
    c4 = {hi, inten[1], lo, inten[0]};
    return {c4, c4};
  endfunction

endpackage

[hw/rtl/tile_map_pixel_generator.sv]
// Tile-map pixel generator: a four-stage pipeline (coordinate mapping,
// name/attribute lookup, pattern fetch, palette lookup) that takes one beat per
// clock unless stalled. Write beats (kind 0) store one byte into the name,
// attribute, pattern or palette memory as they pass the stage that owns that
// memory, so a pixel beat always sees every write accepted before it; write
// beats give no result. Each stage advances whenever the next one is empty or
// moving, so bubbles close up and a stall at the output holds the pipe without
// loss. Memory entries must be written before a pixel reads them. The user must
// write configuration only while idle; the block itself does not enforce this.
// depends on tmpg_pkg and the four stage modules
module tile_map_pixel_generator import tmpg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [1:0]          memory_select_i,
  input  logic [MemAw-1:0]    write_address_i,
  input  logic [DataW-1:0]    write_data_i,
  input  logic [CoordW-1:0]   screen_column_i,
  input  logic [RowW-1:0]     screen_row_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataW-1:0]    red_o,
  output logic [DataW-1:0]    green_o,
  output logic [DataW-1:0]    blue_o
);

  cfg_t cfg_q;
  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEXT_EN:   cfg_q.text_en   <= cfg_wdata_i[0];
        CFG_ZOOM_H:    cfg_q.zoom_h    <= cfg_wdata_i[0];
        CFG_ZOOM_V:    cfg_q.zoom_v    <= cfg_wdata_i[0];
        CFG_SCROLL_H:  cfg_q.scroll_h  <= cfg_wdata_i[CoordW-1:0];
        CFG_SCROLL_V:  cfg_q.scroll_v  <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // stage advance chain, from the output back to the input
  assign load4      = !v4 || out_ready_i;
  assign load3      = !v3 || load4;
  assign load2      = !v2 || load3;
  assign load1      = !v1 || load2;
  assign in_ready_o = load1;

  tmpg_coord u_coord (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load1),
    .in_valid_i      (in_valid_i),
    .kind_i          (kind_i),
    .memory_select_i (memory_select_i),
    .write_address_i (write_address_i),
    .write_data_i    (write_data_i),
    .screen_column_i (screen_column_i),
    .screen_row_i    (screen_row_i),
    .cfg_i           (cfg_q),
    .valid_o         (v1),
    .s1_o            (s1)
  );

  tmpg_tile_lookup u_tile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load2),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v2),
    .s2_o    (s2)
  );

  tmpg_pattern_fetch u_pattern (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load3),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (v3),
    .s3_o    (s3)
  );

  tmpg_palette_out u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load4),
    .valid_i (v3),
    .s3_i    (s3),
    .valid_o (v4),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  assign out_valid_o = v4;

endmodule

[hw/rtl/tmpg_coord.sv]
// tile map pixel generator, first stage: scroll and zoom mapping, tile address
// depends on tmpg_pkg
module tmpg_coord import tmpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              in_valid_i,
  input  logic              kind_i,
  input  logic [1:0]        memory_select_i,
  input  logic [MemAw-1:0]  write_address_i,
  input  logic [DataW-1:0]  write_data_i,
  input  logic [CoordW-1:0] screen_column_i,
  input  logic [RowW-1:0]   screen_row_i,
  input  cfg_t              cfg_i,
  output logic              valid_o,
  output s1_t               s1_o
);

  logic              valid_q;
  s1_t               s1_d, s1_q;
  logic [CoordW-1:0] col_base, row_base, vx, vy;
  logic [TileRowW-1:0] tile_row;

  // offset, zoom and scroll, wrapped to the 1024 plane
  always_comb begin
    if (cfg_i.zoom_h) begin
      col_base = {1'b0, screen_column_i[CoordW-1:1]} + ZoomOfs;
    end else begin
      col_base = screen_column_i + ColOfs;
    end
    if (cfg_i.zoom_v) begin
      row_base = {2'b00, screen_row_i[RowW-1:1]} + ZoomOfs;
    end else begin
      row_base = {1'b0, screen_row_i} + RowOfs;
    end
    vx = col_base + cfg_i.scroll_h;
    vy = row_base + cfg_i.scroll_v;
  end

  // tile address and palette bank
  always_comb begin
    if (cfg_i.text_en) begin
      tile_row = {vy[8:4], vy[9]};
    end else begin
      tile_row = vy[8:3];
    end
    s1_d.kind     = kind_e'(kind_i);
    s1_d.wr.sel   = mem_sel_e'(memory_select_i);
    s1_d.wr.addr  = write_address_i;
    s1_d.wr.data  = write_data_i;
    s1_d.tile     = {tile_row, vx[CoordW-1:PixW]};
    s1_d.px       = vx[PixW-1:0];
    s1_d.py       = vy[PixW-1:0];
    s1_d.bank     = cfg_i.text_en ? vy[3] : vy[9];
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

[hw/rtl/tmpg_tile_lookup.sv]
// tile map pixel generator, second stage: name and attribute memories
// depends on tmpg_pkg
module tmpg_tile_lookup import tmpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic valid_i,
  input  s1_t  s1_i,
  output logic valid_o,
  output s2_t  s2_o
);

  logic [DataW-1:0] name_mem [2**MemAw];
  logic [DataW-1:0] attr_mem [2**MemAw];

  logic             valid_q;
  logic [DataW-1:0] name_q, attr_q;
  s1_t              pass_q;
  logic             wr_beat, wr_name, wr_attr;

  // writes happen as the write beat passes this stage
  assign wr_beat = load_i && valid_i && (s1_i.kind == KIND_WRITE);
  assign wr_name = wr_beat && (s1_i.wr.sel == MEM_NAME);
  assign wr_attr = wr_beat && (s1_i.wr.sel == MEM_ATTR);

  // memory write ports
  always_ff @(posedge clk_i) begin
    if (wr_name) begin
      name_mem[s1_i.wr.addr] <= s1_i.wr.data;
    end
    if (wr_attr) begin
      attr_mem[s1_i.wr.addr] <= s1_i.wr.data;
    end
  end

  // registered reads at the tile address, plus pass-through fields
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      name_q <= name_mem[s1_i.tile];
      attr_q <= attr_mem[s1_i.tile];
      pass_q <= s1_i;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_comb begin
    s2_o.kind = pass_q.kind;
    s2_o.wr   = pass_q.wr;
    s2_o.name = name_q;
    s2_o.attr = attr_q;
    s2_o.px   = pass_q.px;
    s2_o.py   = pass_q.py;
    s2_o.bank = pass_q.bank;
  end

  assign valid_o = valid_q;

endmodule

[hw/rtl/tmpg_pattern_fetch.sv]
// tile map pixel generator, third stage: pattern memory
// depends on tmpg_pkg
module tmpg_pattern_fetch import tmpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic valid_i,
  input  s2_t  s2_i,
  output logic valid_o,
  output s3_t  s3_o
);

  logic [DataW-1:0] pat_mem [2**MemAw];

  logic             valid_q;
  logic [DataW-1:0] pat_q;
  logic [MemAw-1:0] rd_addr;
  logic             wr_pat;
  s3_t              pass_q;

  // pattern address: name, pixel row pair, pixel column
  assign rd_addr = {s2_i.name, s2_i.py[2:1], s2_i.px};
  assign wr_pat  = load_i && valid_i && (s2_i.kind == KIND_WRITE)
                   && (s2_i.wr.sel == MEM_PATTERN);

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_pat) begin
      pat_mem[s2_i.wr.addr] <= s2_i.wr.data;
    end
  end

  // registered read and pass-through fields
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q          <= pat_mem[rd_addr];
      pass_q.kind    <= s2_i.kind;
      pass_q.wr      <= s2_i.wr;
      pass_q.pattern <= '0;
      pass_q.attr    <= s2_i.attr;
      pass_q.hi_nib  <= s2_i.py[0];
      pass_q.bank    <= s2_i.bank;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_comb begin
    s3_o         = pass_q;
    s3_o.pattern = pat_q;
  end

  assign valid_o = valid_q;

endmodule

[hw/rtl/tmpg_palette_out.sv]
// tile map pixel generator, last stage: palette memory and color expansion
// depends on tmpg_pkg
module tmpg_palette_out import tmpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             valid_i,
  input  s3_t              s3_i,
  output logic             valid_o,
  output logic [DataW-1:0] red_o,
  output logic [DataW-1:0] green_o,
  output logic [DataW-1:0] blue_o
);

  logic [DataW-1:0] pal_mem [2**MemAw];

  logic             valid_q;
  logic [DataW-1:0] pal_q;
  logic [NibW-1:0]  nib;
  logic [MemAw-1:0] rd_addr;
  logic             wr_pal;

  // nibble by row parity, then palette address
  assign nib     = s3_i.hi_nib ? s3_i.pattern[7:4] : s3_i.pattern[3:0];
  assign rd_addr = {s3_i.bank, s3_i.attr, nib};
  assign wr_pal  = load_i && valid_i && (s3_i.kind == KIND_WRITE)
                   && (s3_i.wr.sel == MEM_PALETTE);

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_pal) begin
      pal_mem[s3_i.wr.addr] <= s3_i.wr.data;
    end
  end

  // registered read is the output register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pal_q <= pal_mem[rd_addr];
    end
  end

  // only pixel beats become results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i && (s3_i.kind == KIND_PIXEL);
    end
  end

  // RrGgBbIi expansion
  assign red_o   = expand_channel(pal_q[7], pal_q[6], pal_q[1:0]);
  assign green_o = expand_channel(pal_q[5], pal_q[4], pal_q[1:0]);
  assign blue_o  = expand_channel(pal_q[3], pal_q[2], pal_q[1:0]);
  assign valid_o = valid_q;

endmodule
